### hw/rtl/rtc_pkg.sv
// Shared types, register indexes and arithmetic helpers for the RTC register file.
// Used by the front end, the back end and the top level. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rtc_pkg;

    localparam logic [2:0] CMD_WR_INDEX = 3'd0;
    localparam logic [2:0] CMD_RD_INDEX = 3'd1;
    localparam logic [2:0] CMD_WR_DATA  = 3'd2;
    localparam logic [2:0] CMD_RD_DATA  = 3'd3;
    localparam logic [2:0] CMD_TICK     = 3'd4;

    localparam logic [7:0] IDX_SEC  = 8'h00;
    localparam logic [7:0] IDX_MIN  = 8'h02;
    localparam logic [7:0] IDX_HOUR = 8'h04;
    localparam logic [7:0] IDX_WDAY = 8'h06;
    localparam logic [7:0] IDX_DAY  = 8'h07;
    localparam logic [7:0] IDX_MON  = 8'h08;
    localparam logic [7:0] IDX_YEAR = 8'h09;
    localparam logic [7:0] IDX_A    = 8'h0A;
    localparam logic [7:0] IDX_B    = 8'h0B;
    localparam logic [7:0] IDX_C    = 8'h0C;
    localparam logic [7:0] IDX_D    = 8'h0D;
    localparam logic [7:0] IDX_CENT = 8'h32;

    localparam logic [7:0] MOD_MINSEC  = 8'd60;
    localparam logic [7:0] MOD_HOUR    = 8'd24;
    localparam logic [7:0] MOD_WDAY    = 8'd7;
    localparam logic [7:0] MOD_DAY     = 8'd31;
    localparam logic [7:0] MOD_MON     = 8'd12;
    localparam logic [7:0] MOD_CENTURY = 8'd100;
    localparam logic [7:0] MOD_DIGIT   = 8'd10;

    // Reciprocal multipliers and shifts, exact for every byte value.
    localparam logic [9:0] RCP_MINSEC  = 10'd137;
    localparam logic [3:0] SH_MINSEC   = 4'd13;
    localparam logic [9:0] RCP_HOUR    = 10'd171;
    localparam logic [3:0] SH_HOUR     = 4'd12;
    localparam logic [9:0] RCP_WDAY    = 10'd293;
    localparam logic [3:0] SH_WDAY     = 4'd11;
    localparam logic [9:0] RCP_DAY     = 10'd265;
    localparam logic [3:0] SH_DAY      = 4'd13;
    localparam logic [9:0] RCP_MON     = 10'd171;
    localparam logic [3:0] SH_MON      = 4'd11;
    localparam logic [9:0] RCP_CENTURY = 10'd41;
    localparam logic [3:0] SH_CENTURY  = 4'd12;
    localparam logic [9:0] RCP_DIGIT   = 10'd205;
    localparam logic [3:0] SH_DIGIT    = 4'd11;

    localparam int B_BINARY_BIT = 2;
    localparam int B_24H_BIT    = 1;
    localparam logic [7:0] PM_FLAG = 8'h80;

    localparam logic [7:0] RST_CTRL_A = 8'h20;
    localparam logic [7:0] RST_CTRL_B = 8'h02;
    localparam logic [7:0] RST_CTRL_D = 8'h80;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_READ_VAL,
        OP_TICK
    } t_op;

    typedef enum logic [3:0] {
        REG_SEC,
        REG_MIN,
        REG_HOUR,
        REG_WDAY,
        REG_DAY,
        REG_MON,
        REG_YEAR,
        REG_A,
        REG_B,
        REG_C,
        REG_D,
        REG_CENT
    } t_reg;

    typedef struct packed {
        t_op        op;
        t_reg       sel;
        logic [7:0] value;
    } t_item;

    function automatic logic [7:0] rtc_rdiv(input logic [7:0] num, input logic [9:0] rcp,
                                            input logic [3:0] sh);
        logic [17:0] prod;
        logic [17:0] quo;
        prod = {10'd0, num} * {8'd0, rcp};
        quo  = prod >> sh;
        return quo[7:0];
    endfunction

    function automatic logic [7:0] rtc_rmod(input logic [7:0] num, input logic [7:0] den,
                                            input logic [9:0] rcp, input logic [3:0] sh);
        logic [7:0]  quo;
        logic [15:0] qd;
        quo = rtc_rdiv(num, rcp, sh);
        qd  = quo * den;
        return num - qd[7:0];
    endfunction

    function automatic logic [7:0] rtc_mod60(input logic [7:0] v);
        return rtc_rmod(v, MOD_MINSEC, RCP_MINSEC, SH_MINSEC);
    endfunction

    function automatic logic [7:0] rtc_mod24(input logic [7:0] v);
        return rtc_rmod(v, MOD_HOUR, RCP_HOUR, SH_HOUR);
    endfunction

    function automatic logic [7:0] rtc_mod7(input logic [7:0] v);
        return rtc_rmod(v, MOD_WDAY, RCP_WDAY, SH_WDAY);
    endfunction

    function automatic logic [7:0] rtc_mod31(input logic [7:0] v);
        return rtc_rmod(v, MOD_DAY, RCP_DAY, SH_DAY);
    endfunction

    function automatic logic [7:0] rtc_mod12(input logic [7:0] v);
        return rtc_rmod(v, MOD_MON, RCP_MON, SH_MON);
    endfunction

    function automatic logic [7:0] rtc_mod100(input logic [7:0] v);
        return rtc_rmod(v, MOD_CENTURY, RCP_CENTURY, SH_CENTURY);
    endfunction

    function automatic logic [7:0] rtc_bcd(input logic [7:0] v);
        logic [7:0] r;
        logic [7:0] tens;
        logic [7:0] ones;
        r    = rtc_mod100(v);
        tens = rtc_rdiv(r, RCP_DIGIT, SH_DIGIT);
        ones = rtc_rmod(r, MOD_DIGIT, RCP_DIGIT, SH_DIGIT);
        return {tens[3:0], ones[3:0]};
    endfunction

    function automatic logic [4:0] rtc_month_len(input logic [3:0] m);
        logic [4:0] n;
        case (m)
            4'd2:    n = 5'd28;
            4'd4:    n = 5'd30;
            4'd6:    n = 5'd30;
            4'd9:    n = 5'd30;
            4'd11:   n = 5'd30;
            default: n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/rtc_queue.sv
// Small first-in first-out queue of packed words, held in registers.
// Used between the front and back ends and for the results. No package use.
`timescale 1ns / 1ps
`default_nettype none

module rtc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [AW:0]   FULL_COUNT = (AW + 1)'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [AW:0]      r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL_COUNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/rtc_front.sv
// Front end: holds the index register, decodes port transfers into operations.
// Depends on rtc_pkg for the index map, operation types and range reduction.
`timescale 1ns / 1ps
`default_nettype none

module rtc_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [7:0]  i_data,
    output logic             o_push,
    output rtc_pkg::t_item   o_item
);

    logic [7:0] r_index, n_index;
    logic [7:0] day_mod, mon_mod;

    assign day_mod = rtc_pkg::rtc_mod31(i_data);
    assign mon_mod = rtc_pkg::rtc_mod12(i_data);

    always_comb begin
        n_index      = r_index;
        o_push       = 1'b0;
        o_item.op    = rtc_pkg::OP_TICK;
        o_item.sel   = rtc_pkg::REG_SEC;
        o_item.value = i_data;
        case (i_cmd)
            rtc_pkg::CMD_WR_INDEX: begin
                if (i_valid) begin
                    n_index = i_data;
                end
            end
            rtc_pkg::CMD_RD_INDEX: begin
                o_push       = i_valid;
                o_item.op    = rtc_pkg::OP_READ_VAL;
                o_item.value = r_index;
            end
            rtc_pkg::CMD_WR_DATA, rtc_pkg::CMD_RD_DATA: begin
                o_push    = i_valid;
                o_item.op = (i_cmd == rtc_pkg::CMD_WR_DATA) ? rtc_pkg::OP_WRITE
                                                            : rtc_pkg::OP_READ;
                case (r_index)
                    rtc_pkg::IDX_SEC: begin
                        o_item.sel   = rtc_pkg::REG_SEC;
                        o_item.value = rtc_pkg::rtc_mod60(i_data);
                    end
                    rtc_pkg::IDX_MIN: begin
                        o_item.sel   = rtc_pkg::REG_MIN;
                        o_item.value = rtc_pkg::rtc_mod60(i_data);
                    end
                    rtc_pkg::IDX_HOUR: begin
                        o_item.sel   = rtc_pkg::REG_HOUR;
                        o_item.value = rtc_pkg::rtc_mod24(i_data);
                    end
                    rtc_pkg::IDX_WDAY: begin
                        o_item.sel   = rtc_pkg::REG_WDAY;
                        o_item.value = rtc_pkg::rtc_mod7(i_data);
                    end
                    rtc_pkg::IDX_DAY: begin
                        o_item.sel   = rtc_pkg::REG_DAY;
                        o_item.value = (day_mod == '0) ? rtc_pkg::MOD_DAY : day_mod;
                    end
                    rtc_pkg::IDX_MON: begin
                        o_item.sel   = rtc_pkg::REG_MON;
                        o_item.value = (mon_mod == '0) ? rtc_pkg::MOD_MON : mon_mod;
                    end
                    rtc_pkg::IDX_YEAR: begin
                        o_item.sel   = rtc_pkg::REG_YEAR;
                        o_item.value = rtc_pkg::rtc_mod100(i_data);
                    end
                    rtc_pkg::IDX_CENT: begin
                        o_item.sel   = rtc_pkg::REG_CENT;
                        o_item.value = rtc_pkg::rtc_mod100(i_data);
                    end
                    rtc_pkg::IDX_A: o_item.sel = rtc_pkg::REG_A;
                    rtc_pkg::IDX_B: o_item.sel = rtc_pkg::REG_B;
                    rtc_pkg::IDX_C: o_item.sel = rtc_pkg::REG_C;
                    rtc_pkg::IDX_D: o_item.sel = rtc_pkg::REG_D;
                    default: begin
                        // Unused index: writes vanish, reads return zero.
                        o_push       = i_valid && (i_cmd == rtc_pkg::CMD_RD_DATA);
                        o_item.op    = rtc_pkg::OP_READ_VAL;
                        o_item.value = '0;
                    end
                endcase
            end
            rtc_pkg::CMD_TICK: begin
                o_push    = i_valid;
                o_item.op = rtc_pkg::OP_TICK;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
        end else begin
            r_index <= n_index;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/rtc_back.sv
// Back end: control registers, calendar counters, tick carries and read formatting.
// Depends on rtc_pkg for operation types, reset values and BCD conversion.
`timescale 1ns / 1ps
`default_nettype none

module rtc_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    input  wire rtc_pkg::t_item i_item,
    output logic                o_pop,
    input  wire logic           i_res_full,
    output logic                o_res_push,
    output logic [7:0]          o_res_data
);

    logic [7:0] r_ctrl_a, n_ctrl_a;
    logic [7:0] r_ctrl_b, n_ctrl_b;
    logic [7:0] r_ctrl_c, n_ctrl_c;
    logic [7:0] r_ctrl_d, n_ctrl_d;
    logic [5:0] r_sec, n_sec;
    logic [5:0] r_min, n_min;
    logic [4:0] r_hour, n_hour;
    logic [2:0] r_wday, n_wday;
    logic [4:0] r_day, n_day;
    logic [3:0] r_mon, n_mon;
    logic [6:0] r_year, n_year;
    logic [6:0] r_cent, n_cent;

    logic       is_read, run, leap;
    logic [4:0] dim;
    logic [3:0] mon_eff;
    logic [7:0] raw, shown_v, h12_mod, h12;
    logic [7:0] h12_shown;

    assign is_read    = (i_item.op == rtc_pkg::OP_READ) || (i_item.op == rtc_pkg::OP_READ_VAL);
    assign run        = !i_empty && !(is_read && i_res_full);
    assign o_pop      = run;
    assign o_res_push = run && is_read;

    // The year counter stays below 100, so the Gregorian test reduces to these bits.
    assign leap    = (r_year[1:0] == 2'b00) && ((r_year != '0) || (r_cent[1:0] == 2'b00));
    assign mon_eff = (r_mon >= 4'd1 && r_mon <= 4'd12) ? r_mon : 4'd1;
    assign dim     = (mon_eff == 4'd2 && leap) ? 5'd29 : rtc_pkg::rtc_month_len(mon_eff);

    always_comb begin
        case (i_item.sel)
            rtc_pkg::REG_SEC:  raw = {2'b00, r_sec};
            rtc_pkg::REG_MIN:  raw = {2'b00, r_min};
            rtc_pkg::REG_HOUR: raw = {3'b000, r_hour};
            rtc_pkg::REG_WDAY: raw = {5'b00000, r_wday};
            rtc_pkg::REG_DAY:  raw = {3'b000, r_day};
            rtc_pkg::REG_MON:  raw = {4'b0000, r_mon};
            rtc_pkg::REG_YEAR: raw = {1'b0, r_year};
            rtc_pkg::REG_CENT: raw = {1'b0, r_cent};
            default:           raw = '0;
        endcase
    end

    assign shown_v   = r_ctrl_b[rtc_pkg::B_BINARY_BIT] ? raw : rtc_pkg::rtc_bcd(raw);
    assign h12_mod   = rtc_pkg::rtc_mod12({3'b000, r_hour});
    assign h12       = (h12_mod == '0) ? rtc_pkg::MOD_MON : h12_mod;
    assign h12_shown = r_ctrl_b[rtc_pkg::B_BINARY_BIT] ? h12 : rtc_pkg::rtc_bcd(h12);

    always_comb begin
        case (i_item.op)
            rtc_pkg::OP_READ_VAL: o_res_data = i_item.value;
            rtc_pkg::OP_READ: begin
                case (i_item.sel)
                    rtc_pkg::REG_A: o_res_data = r_ctrl_a;
                    rtc_pkg::REG_B: o_res_data = r_ctrl_b;
                    rtc_pkg::REG_C: o_res_data = '0;
                    rtc_pkg::REG_D: o_res_data = r_ctrl_d;
                    rtc_pkg::REG_HOUR: begin
                        if (r_ctrl_b[rtc_pkg::B_24H_BIT]) begin
                            o_res_data = shown_v;
                        end else begin
                            o_res_data = h12_shown
                                       | ((r_hour >= 5'd12) ? rtc_pkg::PM_FLAG : 8'h00);
                        end
                    end
                    default: o_res_data = shown_v;
                endcase
            end
            default: o_res_data = '0;
        endcase
    end

    always_comb begin
        n_ctrl_a = r_ctrl_a;
        n_ctrl_b = r_ctrl_b;
        n_ctrl_c = r_ctrl_c;
        n_ctrl_d = r_ctrl_d;
        n_sec    = r_sec;
        n_min    = r_min;
        n_hour   = r_hour;
        n_wday   = r_wday;
        n_day    = r_day;
        n_mon    = r_mon;
        n_year   = r_year;
        n_cent   = r_cent;
        if (run) begin
            case (i_item.op)
                rtc_pkg::OP_WRITE: begin
                    case (i_item.sel)
                        rtc_pkg::REG_A:    n_ctrl_a = i_item.value;
                        rtc_pkg::REG_B:    n_ctrl_b = i_item.value;
                        rtc_pkg::REG_C:    n_ctrl_c = i_item.value;
                        rtc_pkg::REG_D:    n_ctrl_d = i_item.value;
                        rtc_pkg::REG_SEC:  n_sec    = i_item.value[5:0];
                        rtc_pkg::REG_MIN:  n_min    = i_item.value[5:0];
                        rtc_pkg::REG_HOUR: n_hour   = i_item.value[4:0];
                        rtc_pkg::REG_WDAY: n_wday   = i_item.value[2:0];
                        rtc_pkg::REG_DAY:  n_day    = i_item.value[4:0];
                        rtc_pkg::REG_MON:  n_mon    = i_item.value[3:0];
                        rtc_pkg::REG_YEAR: n_year   = i_item.value[6:0];
                        rtc_pkg::REG_CENT: n_cent   = i_item.value[6:0];
                        default:           n_ctrl_a = r_ctrl_a;
                    endcase
                end
                rtc_pkg::OP_READ: begin
                    if (i_item.sel == rtc_pkg::REG_C) begin
                        n_ctrl_c = '0;
                    end
                end
                rtc_pkg::OP_TICK: begin
                    if ({1'b0, r_sec} + 7'd1 < 7'd60) begin
                        n_sec = r_sec + 6'd1;
                    end else begin
                        n_sec = '0;
                        if ({1'b0, r_min} + 7'd1 < 7'd60) begin
                            n_min = r_min + 6'd1;
                        end else begin
                            n_min = '0;
                            if ({1'b0, r_hour} + 6'd1 < 6'd24) begin
                                n_hour = r_hour + 5'd1;
                            end else begin
                                n_hour = '0;
                                n_wday = (r_wday >= 3'd6) ? 3'd0 : r_wday + 3'd1;
                                if (r_day >= 5'd1 && r_day < dim) begin
                                    n_day = r_day + 5'd1;
                                end else begin
                                    n_day = 5'd1;
                                    if (r_mon >= 4'd1 && r_mon < 4'd12) begin
                                        n_mon = r_mon + 4'd1;
                                    end else begin
                                        n_mon = 4'd1;
                                        if (r_year < 7'd99) begin
                                            n_year = r_year + 7'd1;
                                        end else begin
                                            n_year = '0;
                                            n_cent = (r_cent >= 7'd99) ? 7'd0 : r_cent + 7'd1;
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
                default: n_ctrl_a = r_ctrl_a;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_a <= rtc_pkg::RST_CTRL_A;
            r_ctrl_b <= rtc_pkg::RST_CTRL_B;
            r_ctrl_c <= '0;
            r_ctrl_d <= rtc_pkg::RST_CTRL_D;
            r_sec    <= '0;
            r_min    <= '0;
            r_hour   <= '0;
            r_wday   <= 3'd4;
            r_day    <= 5'd1;
            r_mon    <= 4'd1;
            r_year   <= 7'd70;
            r_cent   <= 7'd19;
        end else begin
            r_ctrl_a <= n_ctrl_a;
            r_ctrl_b <= n_ctrl_b;
            r_ctrl_c <= n_ctrl_c;
            r_ctrl_d <= n_ctrl_d;
            r_sec    <= n_sec;
            r_min    <= n_min;
            r_hour   <= n_hour;
            r_wday   <= n_wday;
            r_day    <= n_day;
            r_mon    <= n_mon;
            r_year   <= n_year;
            r_cent   <= n_cent;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/cmos_rtc_register_file.sv
// Top level of the index-and-data real-time clock register file.
// Instantiates rtc_front, rtc_back and two rtc_queue instances; uses rtc_pkg.
//
//   Channel   Direction  Handshake       Payload
//   command   in         push / full     i_cmd[2:0], i_data[7:0]
//   result    out        pop / empty     o_read_data[7:0]
//
// One transfer per cycle is accepted while full is low and executed in order; a read
// result passes through the operation queue and then the result queue to the ports.
// The operation queue and the result queue each hold OP_DEPTH and RES_DEPTH entries.
// A stalled result side stops a read at the head and every operation behind it.
// Reset is synchronous and active low and restores the power-on calendar.
`timescale 1ns / 1ps
`default_nettype none

module cmos_rtc_register_file #(
    parameter int OP_DEPTH  = 2,
    parameter int RES_DEPTH = 2
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [2:0] i_cmd,
    input  wire logic [7:0] i_data,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_read_data
);

    localparam int ITEM_W = $bits(rtc_pkg::t_item);

    logic           accept;
    logic           op_push, op_pop, op_empty;
    rtc_pkg::t_item op_in, op_out;
    logic           res_push, res_full;
    logic [7:0]     res_data;

    assign accept = push && !full;

    rtc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_cmd   (i_cmd),
        .i_data  (i_data),
        .o_push  (op_push),
        .o_item  (op_in)
    );

    rtc_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (OP_DEPTH)
    ) u_op_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_push),
        .i_data  (op_in),
        .i_pop   (op_pop),
        .o_full  (full),
        .o_empty (op_empty),
        .o_data  (op_out)
    );

    rtc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (op_empty),
        .i_item     (op_out),
        .o_pop      (op_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res_data (res_data)
    );

    rtc_queue #(
        .WIDTH (8),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_data),
        .i_pop   (pop),
        .o_full  (res_full),
        .o_empty (empty),
        .o_data  (o_read_data)
    );

endmodule

`default_nettype wire
